// ----- hdl/crtp_pkg.sv -----
// ----------------------------------------------------------------------------
// crtp_pkg
// Shared types, character codes and constants of the rgba() text parser.
// ----------------------------------------------------------------------------
package crtp_pkg;

  localparam int FRAC_Q = 14;
  localparam int OUT_W  = 24;
  localparam int CNT_W  = 3;
  localparam int OUT_DATA_W = 104;

  localparam logic [OUT_W-1:0] OUT_MAX   = {OUT_W{1'b1}};
  localparam logic [OUT_W-1:0] ALPHA_ONE = 24'd16384;

  localparam logic [CNT_W-1:0] MAX_NUMBERS = 3'd6;
  localparam logic [CNT_W-1:0] CNT_RGB     = 3'd3;
  localparam logic [CNT_W-1:0] CNT_WHOLE   = 3'd4;
  localparam logic [CNT_W-1:0] CNT_FRAC    = 3'd5;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_PCT  = 8'h25;

  // rounding offsets, half of each divisor
  localparam logic [7:0] HALF_255 = 8'd127;
  localparam logic [7:0] HALF_100 = 8'd50;

  // stage advance enables of the result pipeline
  typedef struct packed {
    logic s2_en;
    logic out_en;
  } crtp_adv_t;

  function automatic logic [31:0] pow10(input int unsigned n);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < 9; i++) begin
      if (i < n) r = r * 32'd10;
    end
    return r;
  endfunction

endpackage

// ----- hdl/crtp_scanner.sv -----
// ----------------------------------------------------------------------------
// crtp_scanner
// Character scanner: gathers digit runs into numbers, keeps percent marks and
// the padded alpha fraction, and captures a snapshot on the final character.
// ----------------------------------------------------------------------------
module crtp_scanner #(
  parameter int VB = 10,
  parameter int FD = 4,
  localparam int FRW = $clog2(10 ** FD),
  localparam int FDW = $clog2(FD + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [7:0]                  char_code,
  input  logic                        is_last,
  output logic [2:0][VB-1:0]          snap_ch,
  output logic [2:0]                  snap_pct,
  output logic [VB-1:0]               snap_whole,
  output logic [FRW-1:0]              snap_frac,
  output logic [crtp_pkg::CNT_W-1:0]  snap_cnt
);

  localparam logic [VB+3:0] VMAX = {4'd0, {VB{1'b1}}};

  logic [crtp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       dig_r, dig_nxt;
  logic [VB-1:0]              acc_r, acc_nxt;
  logic [2:0][VB-1:0]         ch_r, ch_nxt;
  logic [2:0]                 pct_r, pct_nxt;
  logic [VB-1:0]              whole_r, whole_nxt;
  logic [FRW-1:0]             frac_r, frac_nxt;
  logic [FDW-1:0]             fdig_r, fdig_nxt;

  logic                       is_digit;
  logic                       start;
  logic [3:0]                 digit;
  logic [VB+3:0]              acc_mul;
  logic [FRW-1:0]             frac_add;

  always_comb begin
    cnt_nxt   = cnt_r;
    dig_nxt   = dig_r;
    acc_nxt   = acc_r;
    ch_nxt    = ch_r;
    pct_nxt   = pct_r;
    whole_nxt = whole_r;
    frac_nxt  = frac_r;
    fdig_nxt  = fdig_r;

    is_digit = (char_code >= crtp_pkg::CH_ZERO) && (char_code <= crtp_pkg::CH_NINE);
    digit    = 4'(char_code - crtp_pkg::CH_ZERO);
    start    = is_digit && !dig_r && (cnt_r < crtp_pkg::MAX_NUMBERS);
    acc_mul  = (start ? '0 : (VB+4)'(acc_r)) * (VB+4)'(10) + (VB+4)'(digit);
    // fraction kept left aligned on FD digits, so one divisor serves all lengths
    frac_add = FRW'(32'(digit) * crtp_pkg::pow10(FD - 1 - int'(fdig_r)));

    if (is_digit) begin
      if (start) begin
        cnt_nxt = cnt_r + 3'd1;
        dig_nxt = 1'b1;
      end
      if (dig_r || start) begin
        acc_nxt = (acc_mul > VMAX) ? VB'(VMAX) : VB'(acc_mul);
        if ((cnt_nxt != '0) && (cnt_nxt <= crtp_pkg::CNT_RGB)) begin
          ch_nxt[2'(cnt_nxt - 3'd1)] = acc_nxt;
        end else if (cnt_nxt == crtp_pkg::CNT_WHOLE) begin
          whole_nxt = acc_nxt;
        end else if ((cnt_nxt == crtp_pkg::CNT_FRAC) && (fdig_r < FDW'(FD))) begin
          frac_nxt = frac_r + frac_add;
          fdig_nxt = fdig_r + FDW'(1);
        end
      end
    end else begin
      dig_nxt = 1'b0;
      if ((char_code == crtp_pkg::CH_PCT) && (cnt_r != '0) && (cnt_r <= crtp_pkg::CNT_RGB)) begin
        pct_nxt[2'(cnt_r - 3'd1)] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && is_last)) begin
      cnt_r   <= '0;
      dig_r   <= 1'b0;
      acc_r   <= '0;
      ch_r    <= '0;
      pct_r   <= '0;
      whole_r <= '0;
      frac_r  <= '0;
      fdig_r  <= '0;
    end else if (take) begin
      cnt_r   <= cnt_nxt;
      dig_r   <= dig_nxt;
      acc_r   <= acc_nxt;
      ch_r    <= ch_nxt;
      pct_r   <= pct_nxt;
      whole_r <= whole_nxt;
      frac_r  <= frac_nxt;
      fdig_r  <= fdig_nxt;
    end
  end

  // snapshot of the finished text
  always_ff @(posedge clk) begin
    if (take && is_last) begin
      snap_ch    <= ch_nxt;
      snap_pct   <= pct_nxt;
      snap_whole <= whole_nxt;
      snap_frac  <= frac_nxt;
      snap_cnt   <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/crtp_chan_scale.sv -----
// ----------------------------------------------------------------------------
// crtp_chan_scale
// Colour channel scaling to Q10.14: value/255 or value/100, rounded half up,
// by reciprocal multiplication over two register stages.
// ----------------------------------------------------------------------------
module crtp_chan_scale #(
  parameter int VB = 10
) (
  input  logic                             clk,
  input  crtp_pkg::crtp_adv_t              adv,
  input  logic [VB-1:0]                    value,
  input  logic                             pct,
  output logic [crtp_pkg::OUT_W-1:0]       result
);

  localparam int CN   = VB + crtp_pkg::FRAC_Q;
  localparam int S255 = CN + 8;
  localparam int S100 = CN + 7;
  localparam logic [63:0] M255 = ((64'd1 << S255) + 64'd254) / 64'd255;
  localparam logic [63:0] M100 = ((64'd1 << S100) + 64'd99) / 64'd100;

  logic [CN-1:0]   num;
  logic [CN:0]     mul_k;
  logic [2*CN:0]   prod_r;
  logic            pct_r;
  logic [2*CN:0]   quo;

  always_comb begin
    num   = {value, {crtp_pkg::FRAC_Q{1'b0}}}
          + CN'(pct ? crtp_pkg::HALF_100 : crtp_pkg::HALF_255);
    mul_k = pct ? M100[CN:0] : M255[CN:0];
    quo   = pct_r ? (prod_r >> S100) : (prod_r >> S255);
  end

  always_ff @(posedge clk) begin
    if (adv.s2_en) begin
      prod_r <= (2*CN+1)'(num) * (2*CN+1)'(mul_k);
      pct_r  <= pct;
    end
    if (adv.out_en) begin
      result <= (|quo[2*CN:crtp_pkg::OUT_W]) ? crtp_pkg::OUT_MAX : quo[crtp_pkg::OUT_W-1:0];
    end
  end

endmodule

// ----- hdl/crtp_alpha_scale.sv -----
// ----------------------------------------------------------------------------
// crtp_alpha_scale
// Alpha in Q10.14 from whole part and padded fraction, plus the number count,
// over two register stages.
// ----------------------------------------------------------------------------
module crtp_alpha_scale #(
  parameter int VB = 10,
  parameter int FD = 4,
  localparam int FRW = $clog2(10 ** FD)
) (
  input  logic                             clk,
  input  crtp_pkg::crtp_adv_t              adv,
  input  logic [VB-1:0]                    whole,
  input  logic [FRW-1:0]                   frac,
  input  logic [crtp_pkg::CNT_W-1:0]       cnt,
  output logic [crtp_pkg::OUT_W-1:0]       alpha,
  output logic [crtp_pkg::CNT_W-1:0]       numbers_seen
);

  // dividing by 10^FD is dividing by 2^FD (folded into the scale) and by 5^FD
  localparam int unsigned P5    = 5 ** FD;
  localparam int unsigned HALF5 = P5 / 2;
  localparam int L5 = $clog2(P5);
  localparam int AN = L5 + crtp_pkg::FRAC_Q + 1;
  localparam int SA = AN + L5;
  localparam logic [63:0] MA = ((64'd1 << SA) + 64'(P5) - 64'd1) / 64'(P5);
  localparam int SW = VB + crtp_pkg::FRAC_Q + 1;

  logic [AN-1:0]                 num;
  logic [2*AN:0]                 prod_r;
  logic [VB-1:0]                 whole_r;
  logic [crtp_pkg::CNT_W-1:0]    cnt_r;
  logic [2*AN:0]                 fq;
  logic [SW-1:0]                 sum;
  logic [crtp_pkg::OUT_W-1:0]    alpha_nxt;

  always_comb begin
    num = AN'({frac, {(crtp_pkg::FRAC_Q - FD){1'b0}}}) + AN'(HALF5);
    fq  = prod_r >> SA;
    sum = SW'({whole_r, {crtp_pkg::FRAC_Q{1'b0}}}) + SW'(fq[crtp_pkg::FRAC_Q:0]);
    if (cnt_r < crtp_pkg::CNT_RGB) begin
      alpha_nxt = '0;
    end else if (cnt_r == crtp_pkg::CNT_RGB) begin
      alpha_nxt = crtp_pkg::ALPHA_ONE;
    end else if (|sum[SW-1:crtp_pkg::OUT_W]) begin
      alpha_nxt = crtp_pkg::OUT_MAX;
    end else begin
      alpha_nxt = sum[crtp_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2_en) begin
      prod_r  <= (2*AN+1)'(num) * (2*AN+1)'(MA[AN:0]);
      whole_r <= whole;
      cnt_r   <= cnt;
    end
    if (adv.out_en) begin
      alpha        <= alpha_nxt;
      numbers_seen <= cnt_r;
    end
  end

endmodule

// ----- hdl/css_rgba_text_parser.sv -----
// ----------------------------------------------------------------------------
// css_rgba_text_parser
// Parses rgba() colour text one character per transfer and returns the
// channels and alpha in Q10.14 on the final character.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tlast
//  in_     | in  | char_code[7:0]                              | is_last
//  out_    | out | red, green, blue, alpha (24 each), count(3) | -
//
//  one character is taken every cycle while in_tready is high; out_tvalid rises
//  once the final character has passed the snapshot, product and output registers
//  reset clears the scanner and all stage valids; no clearing pass
//  a stalled result holds the pipeline; in_tready drops for every character
//  once the snapshot stage is full and cannot move on
// ----------------------------------------------------------------------------
module css_rgba_text_parser #(
  parameter int VALUE_BITS      = 10,
  parameter int FRACTION_DIGITS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // char_code
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [crtp_pkg::OUT_DATA_W-1:0]    out_tdata   // red, green, blue, alpha, numbers_seen
);

  localparam int FRW = $clog2(10 ** FRACTION_DIGITS);

  crtp_pkg::crtp_adv_t               adv;
  logic                              s1_valid_r;
  logic                              s2_valid_r;
  logic                              out_valid_r;
  logic                              s1_ok;
  logic                              take;

  logic [2:0][VALUE_BITS-1:0]        snap_ch;
  logic [2:0]                        snap_pct;
  logic [VALUE_BITS-1:0]             snap_whole;
  logic [FRW-1:0]                    snap_frac;
  logic [crtp_pkg::CNT_W-1:0]        snap_cnt;

  logic [crtp_pkg::OUT_W-1:0]        red;
  logic [crtp_pkg::OUT_W-1:0]        green;
  logic [crtp_pkg::OUT_W-1:0]        blue;
  logic [crtp_pkg::OUT_W-1:0]        alpha;
  logic [crtp_pkg::CNT_W-1:0]        numbers_seen;

  always_comb begin
    adv.out_en = !out_valid_r || out_tready;
    adv.s2_en  = !s2_valid_r || adv.out_en;
    s1_ok      = !s1_valid_r || adv.s2_en;
  end

  assign in_tready  = s1_ok;
  assign take       = in_tvalid && s1_ok;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, numbers_seen, alpha, blue, green, red};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ok) s1_valid_r <= take && in_tlast;
      if (adv.s2_en) s2_valid_r <= s1_valid_r;
      if (adv.out_en) out_valid_r <= s2_valid_r;
    end
  end

  crtp_scanner #(
    .VB (VALUE_BITS),
    .FD (FRACTION_DIGITS)
  ) u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .char_code  (in_tdata),
    .is_last    (in_tlast),
    .snap_ch    (snap_ch),
    .snap_pct   (snap_pct),
    .snap_whole (snap_whole),
    .snap_frac  (snap_frac),
    .snap_cnt   (snap_cnt)
  );

  crtp_chan_scale #(.VB(VALUE_BITS)) u_red (
    .clk    (clk),
    .adv    (adv),
    .value  (snap_ch[0]),
    .pct    (snap_pct[0]),
    .result (red)
  );

  crtp_chan_scale #(.VB(VALUE_BITS)) u_green (
    .clk    (clk),
    .adv    (adv),
    .value  (snap_ch[1]),
    .pct    (snap_pct[1]),
    .result (green)
  );

  crtp_chan_scale #(.VB(VALUE_BITS)) u_blue (
    .clk    (clk),
    .adv    (adv),
    .value  (snap_ch[2]),
    .pct    (snap_pct[2]),
    .result (blue)
  );

  crtp_alpha_scale #(
    .VB (VALUE_BITS),
    .FD (FRACTION_DIGITS)
  ) u_alpha (
    .clk          (clk),
    .adv          (adv),
    .whole        (snap_whole),
    .frac         (snap_frac),
    .cnt          (snap_cnt),
    .alpha        (alpha),
    .numbers_seen (numbers_seen)
  );

  // a final character always lands in the snapshot stage
  a_last_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_tlast |=> s1_valid_r)
    else $error("final character did not reach snapshot stage");

  // a result leaving the product stage reaches the output
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && adv.out_en |=> out_valid_r)
    else $error("result lost between product and output stage");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (numbers_seen != 3'd7))
    else $error("number count out of range");

  // fewer than three numbers gives a transparent colour
  a_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (numbers_seen < crtp_pkg::CNT_RGB) |-> (alpha == '0))
    else $error("alpha not zero for short text");

endmodule

// ----- tb/css_rgba_text_parser_checker.sv -----
// ----------------------------------------------------------------------------
// css_rgba_text_parser_checker
// Watches both streams of the rgba() text parser. It scans every accepted
// character with its own copy of the parser state, queues the colour that
// each final character should produce and compares every result field.
// ----------------------------------------------------------------------------
module css_rgba_text_parser_checker #(
  parameter int VALUE_BITS      = 10,
  parameter int FRACTION_DIGITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // char_code
  input  logic                            in_tlast,   // is_last
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [crtp_pkg::OUT_DATA_W-1:0] out_tdata,  // red, green, blue, alpha, numbers_seen
  output int                              mismatches,
  output int                              pending
);

  localparam int unsigned VALUE_TOP = (1 << VALUE_BITS) - 1;

  typedef struct {
    logic [crtp_pkg::OUT_W-1:0] red;
    logic [crtp_pkg::OUT_W-1:0] green;
    logic [crtp_pkg::OUT_W-1:0] blue;
    logic [crtp_pkg::OUT_W-1:0] alpha;
    logic [crtp_pkg::CNT_W-1:0] count;
  } colour_t;

  colour_t expected_colours[$];

  // scanner state
  logic [crtp_pkg::CNT_W-1:0] seen;
  logic                       in_run;
  logic [VALUE_BITS-1:0]      acc;
  logic [VALUE_BITS-1:0]      chan[3];
  logic [2:0]                 pct;
  logic [VALUE_BITS-1:0]      whole;
  int unsigned                frac;
  logic [crtp_pkg::CNT_W-1:0] frac_n;
  int                         colours_checked;

  initial begin
    mismatches = 0;
    pending = 0;
    colours_checked = 0;
  end

  task automatic clear_scanner();
    seen = '0;
    in_run = 1'b0;
    acc = '0;
    for (int i = 0; i < 3; i++) chan[i] = '0;
    pct = '0;
    whole = '0;
    frac = 0;
    frac_n = '0;
  endtask

  function automatic logic [crtp_pkg::OUT_W-1:0] clip24(input longint unsigned v);
    return (v > 64'(crtp_pkg::OUT_MAX)) ? crtp_pkg::OUT_MAX : v[crtp_pkg::OUT_W-1:0];
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic last);
    int unsigned d;
    int unsigned grown;
    longint unsigned den;
    longint unsigned a;
    longint unsigned scale;
    colour_t col;
    if (c >= crtp_pkg::CH_ZERO && c <= crtp_pkg::CH_NINE) begin
      d = 32'(c - crtp_pkg::CH_ZERO);
      if (!in_run && seen < crtp_pkg::MAX_NUMBERS) begin
        seen = seen + 3'd1;
        acc = '0;
        in_run = 1'b1;
      end
      if (in_run) begin
        grown = 32'(acc) * 32'd10 + d;
        acc = (grown > VALUE_TOP) ? VALUE_BITS'(VALUE_TOP) : VALUE_BITS'(grown);
        if (seen >= 3'd1 && seen <= crtp_pkg::CNT_RGB) begin
          chan[seen - 3'd1] = acc;
        end else if (seen == crtp_pkg::CNT_WHOLE) begin
          whole = acc;
        end else if (seen == crtp_pkg::CNT_FRAC && frac_n < FRACTION_DIGITS) begin
          frac = frac * 10 + d;
          frac_n = frac_n + 3'd1;
        end
      end
    end else begin
      in_run = 1'b0;
      // percent only marks one of the three colour channels
      if (c == crtp_pkg::CH_PCT && seen >= 3'd1 && seen <= crtp_pkg::CNT_RGB)
        pct[seen - 3'd1] = 1'b1;
    end

    if (last) begin
      for (int i = 0; i < 3; i++) begin
        den = pct[i] ? 64'd100 : 64'd255;
        a = (64'(chan[i]) * 64'd16384 + den / 64'd2) / den;
        case (i)
          0: col.red = clip24(a);
          1: col.green = clip24(a);
          default: col.blue = clip24(a);
        endcase
      end
      if (seen < crtp_pkg::CNT_RGB) begin
        a = 64'd0;
      end else if (seen == crtp_pkg::CNT_RGB) begin
        a = 64'(crtp_pkg::ALPHA_ONE);
      end else begin
        a = 64'(whole) * 64'd16384;
        if (frac_n != '0) begin
          scale = 64'd1;
          for (int i = 0; i < int'(frac_n); i++) scale = scale * 64'd10;
          a = a + (64'(frac) * 64'd16384 + scale / 64'd2) / scale;
        end
      end
      col.alpha = clip24(a);
      col.count = seen;
      expected_colours.push_back(col);
      clear_scanner();
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on colour %0d, %s: got %0d, want %0d", colours_checked, what, got,
             want);
    mismatches++;
  endtask

  task automatic check_colour(input logic [crtp_pkg::OUT_DATA_W-1:0] data);
    colour_t want;
    if (expected_colours.size() == 0) begin
      report_mismatch("result with nothing pending", 1, 0);
    end else begin
      want = expected_colours.pop_front();
      if (data[0*crtp_pkg::OUT_W +: crtp_pkg::OUT_W] !== want.red)
        report_mismatch("red", data[0*crtp_pkg::OUT_W +: crtp_pkg::OUT_W], want.red);
      if (data[1*crtp_pkg::OUT_W +: crtp_pkg::OUT_W] !== want.green)
        report_mismatch("green", data[1*crtp_pkg::OUT_W +: crtp_pkg::OUT_W], want.green);
      if (data[2*crtp_pkg::OUT_W +: crtp_pkg::OUT_W] !== want.blue)
        report_mismatch("blue", data[2*crtp_pkg::OUT_W +: crtp_pkg::OUT_W], want.blue);
      if (data[3*crtp_pkg::OUT_W +: crtp_pkg::OUT_W] !== want.alpha)
        report_mismatch("alpha", data[3*crtp_pkg::OUT_W +: crtp_pkg::OUT_W], want.alpha);
      if (data[4*crtp_pkg::OUT_W +: crtp_pkg::CNT_W] !== want.count)
        report_mismatch("numbers_seen", data[4*crtp_pkg::OUT_W +: crtp_pkg::CNT_W],
                        want.count);
    end
    colours_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scanner();
    end else begin
      if (out_tvalid && out_tready) check_colour(out_tdata);
      if (in_tvalid && in_tready) parse_char(in_tdata, in_tlast);
    end
    pending = expected_colours.size();
  end

endmodule

// ----- tb/css_rgba_text_parser_test.sv -----
// ----------------------------------------------------------------------------
// css_rgba_text_parser_test
// Feeds rgba() colour texts to the parser one character per transfer: a few
// hand-picked texts, then mostly well-formed random texts with some noise,
// under random idling on both streams. The checker does the comparing.
// ----------------------------------------------------------------------------
module css_rgba_text_parser_test;

  localparam int VALUE_BITS      = 10;
  localparam int FRACTION_DIGITS = 4;
  localparam int CHAR_TARGET     = 1600;
  localparam int IDLE_LIMIT      = 2000;

  logic clk;
  logic rst_n = 1'b0;

  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [7:0]                        in_tdata  = 8'h00;   // char_code
  logic                              in_tlast  = 1'b0;    // is_last
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [crtp_pkg::OUT_DATA_W-1:0]   out_tdata;           // red, green, blue, alpha, numbers_seen

  int  mismatches;
  int  pending;
  int  chars_sent = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  logic [7:0] text_chars[$];

  css_rgba_text_parser #(
    .VALUE_BITS     (VALUE_BITS),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  css_rgba_text_parser_checker #(
    .VALUE_BITS     (VALUE_BITS),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 37);
  end

  // ends the run when neither stream has moved for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    calm = (chars_sent >= 600 && chars_sent < 900);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_chars.size(); i++)
      send_char(text_chars[i], i == text_chars.size() - 1);
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++)
      text_chars.push_back(8'(32'(crtp_pkg::CH_ZERO) + $urandom_range(0, 9)));
  endtask

  task automatic build_colour_text();
    int r;
    int nums;
    r = $urandom_range(0, 15);
    nums = (r < 2) ? $urandom_range(0, 2) : (r < 6) ? 3 : (r < 12) ? 5 : $urandom_range(4, 8);
    if ($urandom_range(0, 3) != 0) add_string("rgba(");
    if ($urandom_range(0, 19) == 0) add_string("%");
    for (int k = 0; k < nums; k++) begin
      if (k == 4) begin
        add_string(".");
      end else if (k > 0) begin
        case ($urandom_range(0, 2))
          0: add_string(",");
          1: add_string(" ");
          default: add_string(", ");
        endcase
      end
      if (k == 4)
        add_digits($urandom_range(1, 6));
      else if ($urandom_range(0, 9) == 0)
        add_digits($urandom_range(4, 7));   // saturating values
      else
        add_digits($urandom_range(1, 3));
      if ($urandom_range(0, 9) < 3) add_string("%");
    end
    // sometimes the closing bracket is left off, so the text ends on a digit or a mark
    if ($urandom_range(0, 7) != 0 || text_chars.size() == 0) add_string(")");
  endtask

  task automatic build_noise_text(input bit mostly_digits);
    int n;
    n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      if (mostly_digits && $urandom_range(0, 9) < 5)
        add_digits(1);
      else if (mostly_digits && $urandom_range(0, 9) < 4)
        add_string("%");
      else
        text_chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int kind;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // percent before any number, too few numbers
    text_chars = {};
    add_string("%7");
    send_text();
    // saturated value, percent channels, final character a digit
    text_chars = {};
    add_string("9999%5%0");
    send_text();
    // leading fraction zeros, long fraction, sixth and seventh numbers
    text_chars = {};
    add_string("1,2,3,1023.000559,8%9");
    send_text();

    while (chars_sent < CHAR_TARGET) begin
      text_chars = {};
      kind = $urandom_range(0, 99);
      if (kind < 80)
        build_colour_text();
      else
        build_noise_text(kind >= 90);
      send_text();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/crtp_pkg.sv
hdl/crtp_scanner.sv
hdl/crtp_chan_scale.sv
hdl/crtp_alpha_scale.sv
hdl/css_rgba_text_parser.sv
tb/css_rgba_text_parser_checker.sv
tb/css_rgba_text_parser_test.sv
